[hw/rtl/rar_pkg.sv]
// Shared types, widths, codes and the microprogram of the rational arithmetic block.
package rar_pkg;

    // Operand and result widths.
    localparam int OPERAND_WIDTH = 16;
    localparam int DEN_IN_W      = OPERAND_WIDTH - 1;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int NUM_OUT_W     = PROD_W + 1;
    localparam int DEN_OUT_W     = PROD_W - 1;
    localparam int MAG_W         = PROD_W;
    localparam int CNT_W         = $clog2(MAG_W);
    localparam int STATUS_W      = 2;

    // Operation codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd2;

    // Request and response payloads.
    typedef struct packed {
        logic [1:0]                      op;
        logic signed [OPERAND_WIDTH-1:0] num_a;
        logic [DEN_IN_W-1:0]             den_a;
        logic signed [OPERAND_WIDTH-1:0] num_b;
        logic [DEN_IN_W-1:0]             den_b;
    } req_t;

    typedef struct packed {
        logic signed [NUM_OUT_W-1:0] num_out;
        logic [DEN_OUT_W-1:0]        den_out;
        logic [STATUS_W-1:0]         status;
    } rsp_t;

    // Datapath micro-operations.
    typedef enum logic [3:0] {
        U_NOP    = 4'd0,
        U_LOAD   = 4'd1,
        U_CHECK  = 4'd2,
        U_MUL_A  = 4'd3,
        U_MUL_B  = 4'd4,
        U_MUL_C  = 4'd5,
        U_FORM   = 4'd6,
        U_TWOS   = 4'd7,
        U_REDUCE = 4'd8,
        U_GSET   = 4'd9,
        U_DIV    = 4'd10,
        U_FIN    = 4'd11,
        U_EMIT   = 4'd12
    } uop_t;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER     = 4'd0,
        C_ALWAYS    = 4'd1,
        C_NO_REQ    = 4'd2,
        C_ERR       = 4'd3,
        C_UN_ZERO   = 4'd4,
        C_BOTH_EVEN = 4'd5,
        C_NEQ       = 4'd6,
        C_CNT_NZ    = 4'd7,
        C_RSP_FREE  = 4'd8
    } cond_t;

    // Program step addresses.
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
    localparam logic [PC_W-1:0] PC_MUL_A = 4'd2;
    localparam logic [PC_W-1:0] PC_MUL_B = 4'd3;
    localparam logic [PC_W-1:0] PC_MUL_C = 4'd4;
    localparam logic [PC_W-1:0] PC_FORM  = 4'd5;
    localparam logic [PC_W-1:0] PC_ZCHK  = 4'd6;
    localparam logic [PC_W-1:0] PC_TWOS  = 4'd7;
    localparam logic [PC_W-1:0] PC_RED   = 4'd8;
    localparam logic [PC_W-1:0] PC_GSET  = 4'd9;
    localparam logic [PC_W-1:0] PC_DIV   = 4'd10;
    localparam logic [PC_W-1:0] PC_FIN   = 4'd11;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd12;
    localparam logic [PC_W-1:0] PC_WAIT  = 4'd13;

    // One control word: operation, jump condition, jump target.
    typedef struct packed {
        uop_t            uop;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucw_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic err;
        logic un_zero;
        logic both_even;
        logic neq;
        logic cnt_nz;
    } flags_t;

    // Microprogram ROM. A taken condition jumps to the target, otherwise
    // the step counter advances by one.
    function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
        ucw_t w;
        unique case (pc)
            PC_IDLE:  w = '{U_LOAD,   C_NO_REQ,    PC_IDLE};
            PC_CHECK: w = '{U_CHECK,  C_ERR,       PC_EMIT};
            PC_MUL_A: w = '{U_MUL_A,  C_NEVER,     PC_IDLE};
            PC_MUL_B: w = '{U_MUL_B,  C_NEVER,     PC_IDLE};
            PC_MUL_C: w = '{U_MUL_C,  C_NEVER,     PC_IDLE};
            PC_FORM:  w = '{U_FORM,   C_NEVER,     PC_IDLE};
            PC_ZCHK:  w = '{U_NOP,    C_UN_ZERO,   PC_EMIT};
            PC_TWOS:  w = '{U_TWOS,   C_BOTH_EVEN, PC_TWOS};
            PC_RED:   w = '{U_REDUCE, C_NEQ,       PC_RED};
            PC_GSET:  w = '{U_GSET,   C_NEVER,     PC_IDLE};
            PC_DIV:   w = '{U_DIV,    C_CNT_NZ,    PC_DIV};
            PC_FIN:   w = '{U_FIN,    C_NEVER,     PC_IDLE};
            PC_EMIT:  w = '{U_EMIT,   C_RSP_FREE,  PC_IDLE};
            PC_WAIT:  w = '{U_NOP,    C_ALWAYS,    PC_EMIT};
            default:  w = '{U_NOP,    C_ALWAYS,    PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/rational_arith_reduce_top.sv]
// Top level: microcoded sequencer, datapath instance and response register.
// The program runs check, three multiply steps, form, a zero check, the common-twos
// and binary gcd loops, the divider and finish; errors and a zero numerator go to emit.
// Throughput: one item at a time; the gcd loop and the 32-step shared-divisor
// divider hold each item, and emit waits until the response slot is free.
// Reset clears the step counter and the response valid flag; no clearing pass.
module rational_arith_reduce_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rar_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rar_pkg::rsp_t rsp
);

    logic [rar_pkg::PC_W-1:0] pc_reg;
    logic [rar_pkg::PC_W-1:0] pc_next;
    rar_pkg::ucw_t            ucw;
    rar_pkg::uop_t            uop;
    rar_pkg::flags_t          flags;
    rar_pkg::rsp_t            dp_res;
    rar_pkg::rsp_t            rsp_reg;
    logic                     rsp_valid_reg;
    logic                     rsp_free;
    logic                     taken;

    // Fetch the control word for the current step.
    assign ucw       = rar_pkg::ucode(pc_reg);
    assign req_ready = (pc_reg == rar_pkg::PC_IDLE);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // Operand capture only on an actual transfer.
    assign uop = (ucw.uop == rar_pkg::U_LOAD && !req_valid) ? rar_pkg::U_NOP : ucw.uop;

    // Jump condition select.
    always_comb
    begin
        unique case (ucw.cond)
            rar_pkg::C_NEVER:     taken = 1'b0;
            rar_pkg::C_ALWAYS:    taken = 1'b1;
            rar_pkg::C_NO_REQ:    taken = !req_valid;
            rar_pkg::C_ERR:       taken = flags.err;
            rar_pkg::C_UN_ZERO:   taken = flags.un_zero;
            rar_pkg::C_BOTH_EVEN: taken = flags.both_even;
            rar_pkg::C_NEQ:       taken = flags.neq;
            rar_pkg::C_CNT_NZ:    taken = flags.cnt_nz;
            rar_pkg::C_RSP_FREE:  taken = rsp_free;
            default:              taken = 1'b0;
        endcase
    end

    assign pc_next = taken ? ucw.target : pc_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= rar_pkg::PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    rar_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .uop   (uop),
        .req   (req),
        .flags (flags),
        .res   (dp_res)
    );

    // Response register: loaded by the emit step when the slot is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ucw.uop == rar_pkg::U_EMIT && rsp_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ucw.uop == rar_pkg::U_EMIT && rsp_free)
        begin
            rsp_reg <= dp_res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A good result always has a nonzero denominator.
    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status == rar_pkg::ST_OK) |-> (rsp_reg.den_out != '0))
        else $error("ok result with zero denominator");

    // An error result carries zero fields.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != rar_pkg::ST_OK)
        |-> (rsp_reg.num_out == '0) && (rsp_reg.den_out == '0))
        else $error("error result with nonzero fields");

    // An accepted request starts the program at the check step.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (pc_reg == rar_pkg::PC_CHECK))
        else $error("sequencer did not start after a request transfer");

    // The emit step with a free slot always produces a valid response.
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (ucw.uop == rar_pkg::U_EMIT && rsp_free) |=> rsp_valid_reg)
        else $error("emit step lost its response");

endmodule

[hw/rtl/rar_datapath.sv]
// Datapath: operand registers, shared multiplier, binary gcd unit and two divider lanes.
module rar_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  rar_pkg::uop_t   uop,
    input  rar_pkg::req_t   req,
    output rar_pkg::flags_t flags,
    output rar_pkg::rsp_t   res
);

    localparam int OW  = rar_pkg::OPERAND_WIDTH;
    localparam int PW  = rar_pkg::PROD_W;
    localparam int NW  = rar_pkg::NUM_OUT_W;
    localparam int MW  = rar_pkg::MAG_W;
    localparam int CW  = rar_pkg::CNT_W;
    localparam int DOW = rar_pkg::DEN_OUT_W;

    // One restoring division step: returns the new remainder and quotient.
    function automatic logic [2*MW:0] div_step(input logic [MW:0]   rem,
                                               input logic [MW-1:0] quo,
                                               input logic [MW-1:0] dvs);
        logic [MW:0]   sh;
        logic [MW+1:0] trial;
        sh    = {rem[MW-1:0], quo[MW-1]};
        trial = {1'b0, sh} - {2'b00, dvs};
        if (!trial[MW+1])
        begin
            return {trial[MW:0], quo[MW-2:0], 1'b1};
        end
        return {sh, quo[MW-2:0], 1'b0};
    endfunction

    logic [1:0]                      op_reg;
    logic signed [OW-1:0]            na_reg;
    logic signed [OW-1:0]            nb_reg;
    logic [rar_pkg::DEN_IN_W-1:0]    da_reg;
    logic [rar_pkg::DEN_IN_W-1:0]    db_reg;
    logic signed [PW-1:0]            t1_reg;
    logic signed [PW-1:0]            t2_reg;
    logic signed [PW-1:0]            t3_reg;
    logic                            neg_reg;
    logic [MW-1:0]                   ga_reg;
    logic [MW-1:0]                   gb_reg;
    logic [CW-1:0]                   k_reg;
    logic [MW-1:0]                   g_reg;
    logic [MW:0]                     rn_reg;
    logic [MW:0]                     rd_reg;
    logic [MW-1:0]                   qn_reg;
    logic [MW-1:0]                   qd_reg;
    logic [CW-1:0]                   cnt_reg;
    logic [CW-1:0]                   cnt_next;
    rar_pkg::rsp_t                   res_reg;

    logic signed [OW-1:0]            mul_x;
    logic signed [OW-1:0]            mul_y;
    logic signed [PW-1:0]            prod;
    logic [NW-1:0]                   t1_ext;
    logic [NW-1:0]                   t2_ext;
    logic [NW-1:0]                   n_sum;
    logic [NW-1:0]                   n_abs;
    logic [PW-1:0]                   d_sel;
    logic [PW-1:0]                   d_abs;
    logic [MW:0]                     diff_ab;
    logic [MW:0]                     diff_ba;
    logic [2*MW:0]                   step_n;
    logic [2*MW:0]                   step_d;
    logic [NW-1:0]                   qn_ext;
    logic                            zero_den;
    logic                            div_zero;

    // Error detection on the captured operands.
    assign zero_den = (da_reg == '0) || (db_reg == '0);
    assign div_zero = (op_reg == rar_pkg::OP_DIV) && (nb_reg == '0);

    // Shared signed multiplier: operand selection per multiply step.
    always_comb
    begin
        mul_x = na_reg;
        mul_y = nb_reg;
        case (uop)
            rar_pkg::U_MUL_A:
            begin
                mul_x = na_reg;
                mul_y = (op_reg == rar_pkg::OP_MUL) ? nb_reg : $signed({1'b0, db_reg});
            end
            rar_pkg::U_MUL_B:
            begin
                mul_x = nb_reg;
                mul_y = $signed({1'b0, da_reg});
            end
            rar_pkg::U_MUL_C:
            begin
                mul_x = $signed({1'b0, da_reg});
                mul_y = $signed({1'b0, db_reg});
            end
            default:
            begin
                mul_x = na_reg;
                mul_y = nb_reg;
            end
        endcase
    end

    assign prod = mul_x * mul_y;

    // Cross-product combination and magnitudes.
    assign t1_ext = {t1_reg[PW-1], t1_reg};
    assign t2_ext = {t2_reg[PW-1], t2_reg};

    always_comb
    begin
        case (op_reg)
            rar_pkg::OP_ADD: n_sum = t1_ext + t2_ext;
            rar_pkg::OP_SUB: n_sum = t1_ext - t2_ext;
            default:         n_sum = t1_ext;
        endcase
    end

    assign n_abs = n_sum[NW-1] ? (~n_sum + 1'b1) : n_sum;
    assign d_sel = (op_reg == rar_pkg::OP_DIV) ? t2_reg : t3_reg;
    assign d_abs = d_sel[PW-1] ? (~d_sel + 1'b1) : d_sel;

    // Binary gcd subtractors.
    assign diff_ab = {1'b0, ga_reg} - {1'b0, gb_reg};
    assign diff_ba = {1'b0, gb_reg} - {1'b0, ga_reg};

    // Divider lanes for numerator and denominator, sharing the divisor.
    assign step_n = div_step(rn_reg, qn_reg, g_reg);
    assign step_d = div_step(rd_reg, qd_reg, g_reg);
    assign qn_ext = {1'b0, qn_reg};

    // Step counter for the division loop.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (uop == rar_pkg::U_GSET)
        begin
            cnt_next = CW'(MW - 1);
        end
        else if (uop == rar_pkg::U_DIV)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Datapath registers, written under control of the micro-operation.
    always_ff @(posedge clk)
    begin
        case (uop)
            rar_pkg::U_LOAD:
            begin
                op_reg <= req.op;
                na_reg <= req.num_a;
                da_reg <= req.den_a;
                nb_reg <= req.num_b;
                db_reg <= req.den_b;
            end
            rar_pkg::U_CHECK:
            begin
                res_reg.num_out <= '0;
                res_reg.den_out <= '0;
                if (zero_den)
                begin
                    res_reg.status <= rar_pkg::ST_ZERO_DEN;
                end
                else if (div_zero)
                begin
                    res_reg.status <= rar_pkg::ST_DIV_ZERO;
                end
                else
                begin
                    res_reg.status <= rar_pkg::ST_OK;
                end
            end
            rar_pkg::U_MUL_A: t1_reg <= prod;
            rar_pkg::U_MUL_B: t2_reg <= prod;
            rar_pkg::U_MUL_C: t3_reg <= prod;
            rar_pkg::U_FORM:
            begin
                ga_reg  <= n_abs[MW-1:0];
                gb_reg  <= d_abs;
                qn_reg  <= n_abs[MW-1:0];
                qd_reg  <= d_abs;
                k_reg   <= '0;
                neg_reg <= n_sum[NW-1] ^ d_sel[PW-1];
                // A zero numerator leaves this 0/1 result in place.
                res_reg.num_out <= '0;
                res_reg.den_out <= DOW'(1);
            end
            rar_pkg::U_TWOS:
            begin
                // Strip factors of two common to both values.
                if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_reg <= ga_reg >> 1;
                    gb_reg <= gb_reg >> 1;
                    k_reg  <= k_reg + 1'b1;
                end
            end
            rar_pkg::U_REDUCE:
            begin
                // Remove one bit per step: halve an even value, or replace the
                // larger odd value by half the difference.
                if (!ga_reg[0])
                begin
                    ga_reg <= ga_reg >> 1;
                end
                else if (!gb_reg[0])
                begin
                    gb_reg <= gb_reg >> 1;
                end
                else if (!diff_ab[MW] && (diff_ab != '0))
                begin
                    ga_reg <= diff_ab[MW:1];
                end
                else if (!diff_ba[MW] && (diff_ba != '0))
                begin
                    gb_reg <= diff_ba[MW:1];
                end
            end
            rar_pkg::U_GSET:
            begin
                g_reg  <= ga_reg << k_reg;
                rn_reg <= '0;
                rd_reg <= '0;
            end
            rar_pkg::U_DIV:
            begin
                rn_reg <= step_n[2*MW:MW];
                qn_reg <= step_n[MW-1:0];
                rd_reg <= step_d[2*MW:MW];
                qd_reg <= step_d[MW-1:0];
            end
            rar_pkg::U_FIN:
            begin
                res_reg.num_out <= neg_reg ? (~qn_ext + 1'b1) : qn_ext;
                res_reg.den_out <= qd_reg[DOW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Flags for the sequencer.
    assign flags.err       = zero_den || div_zero;
    assign flags.un_zero   = (ga_reg == '0);
    assign flags.both_even = !ga_reg[0] && !gb_reg[0];
    assign flags.neq       = (ga_reg != gb_reg);
    assign flags.cnt_nz    = (cnt_reg != '0);
    assign res             = res_reg;

    // The reduction loop always has at least one odd value.
    a_reduce_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (uop == rar_pkg::U_REDUCE) |-> (ga_reg[0] || gb_reg[0]))
        else $error("gcd reduction entered with both values even");

    // The divisor is never zero while dividing.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (uop == rar_pkg::U_DIV) |-> (g_reg != '0))
        else $error("division by a zero gcd");

    // The common-twos loop never starts from a zero value.
    a_twos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (uop == rar_pkg::U_TWOS) |-> (ga_reg != '0) && (gb_reg != '0))
        else $error("gcd started with a zero operand");

endmodule
